// ===== hw/rtl/lslp_pkg.sv =====
// Lock state LED probe package: register indexes, reset values, status codes
// and the configuration struct shared by lslp_cfg and lock_state_led_probe.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lslp_pkg;

    localparam int TIME_W = 16;
    localparam int ADDR_W = 8;
    localparam int STAT_W = 4;
    localparam int IDX_W  = 3;

    typedef logic [TIME_W-1:0] ms_t;
    typedef logic [ADDR_W-1:0] addr_t;
    typedef logic [STAT_W-1:0] status_t;
    typedef logic [IDX_W-1:0]  reg_idx_t;

    localparam reg_idx_t REG_RELEASE_TO = 3'd0;
    localparam reg_idx_t REG_LEDS_ON_TO = 3'd1;
    localparam reg_idx_t REG_LEDS_OFF_TO = 3'd2;
    localparam reg_idx_t REG_SETTLE = 3'd3;
    localparam reg_idx_t REG_HOLD_TO = 3'd4;
    localparam reg_idx_t REG_BLINK_WIN = 3'd5;

    localparam ms_t RST_RELEASE_TO = 16'd1000;
    localparam ms_t RST_LEDS_ON_TO = 16'd200;
    localparam ms_t RST_LEDS_OFF_TO = 16'd3000;
    localparam ms_t RST_SETTLE = 16'd1000;
    localparam ms_t RST_HOLD_TO = 16'd2500;
    localparam ms_t RST_BLINK_WIN = 16'd10000;

    localparam status_t ST_INTERNAL = 4'd0;
    localparam status_t ST_NOT_ON = 4'd1;
    localparam status_t ST_NOT_OFF = 4'd2;
    localparam status_t ST_UNCALIB = 4'd3;
    localparam status_t ST_UNLOCKED = 4'd4;
    localparam status_t ST_LOCKED = 4'd5;
    localparam status_t ST_NO_CONN = 4'd6;
    localparam status_t ST_NO_RESP = 4'd7;
    localparam status_t ST_AGAIN = 4'd8;

    localparam logic KIND_PRESS = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    typedef struct packed {
        ms_t release_to;
        ms_t leds_on_to;
        ms_t leds_off_to;
        ms_t settle;
        ms_t hold_to;
        ms_t blink_win;
    } lslp_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lslp_cfg.sv =====
// Configuration register file of the lock state LED probe.
// Depends on lslp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lslp_cfg (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire lslp_pkg::reg_idx_t cfg_index,
    input  wire lslp_pkg::ms_t     cfg_data,
    output lslp_pkg::lslp_cfg_t    cfg
);
    import lslp_pkg::*;

    lslp_cfg_t cfg_reg;
    lslp_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_RELEASE_TO:  cfg_next.release_to  = cfg_data;
                REG_LEDS_ON_TO:  cfg_next.leds_on_to  = cfg_data;
                REG_LEDS_OFF_TO: cfg_next.leds_off_to = cfg_data;
                REG_SETTLE:      cfg_next.settle      = cfg_data;
                REG_HOLD_TO:     cfg_next.hold_to     = cfg_data;
                REG_BLINK_WIN:   cfg_next.blink_win   = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.release_to  <= RST_RELEASE_TO;
            cfg_reg.leds_on_to  <= RST_LEDS_ON_TO;
            cfg_reg.leds_off_to <= RST_LEDS_OFF_TO;
            cfg_reg.settle      <= RST_SETTLE;
            cfg_reg.hold_to     <= RST_HOLD_TO;
            cfg_reg.blink_win   <= RST_BLINK_WIN;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/lock_state_led_probe.sv =====
// Lock state LED probe, top level: input register, probe sequencer, result register.
// Depends on lslp_pkg and lslp_cfg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries either a time sample with pin
//   levels (cmd 0) or a lock state request (cmd 1). Each transaction yields
//   zero or one result transaction on the output channel (out_valid/out_ready):
//   a press request (kind 0) or a status reply (kind 1) to dest_addr.
//   A result is registered: the input register is evaluated into the result
//   register, which presents it on the output channel. Throughput: one input
//   transaction per cycle while in_ready is high, set by the update of the
//   sequencer state (one wrapped subtraction and compare).
//   When the receiver stalls, the result register holds its transaction; the
//   input register still drains items that give no result, and in_ready drops
//   only while an item with a result waits behind a full result register.
//   Reset clears the sequencer to idle, empties both registers and loads the
//   default timeouts. Registers are written through cfg_we/cfg_index/cfg_data
//   while the block is idle, a rule for the user that the block does not
//   enforce; indexes above five are ignored.
`timescale 1ns / 1ps
`default_nettype none

module lock_state_led_probe (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic               cmd,
    input  wire lslp_pkg::addr_t    requester,
    input  wire lslp_pkg::ms_t      now_ms,
    input  wire logic               btn_released,
    input  wire logic               led_red,
    input  wire logic               led_grn,
    input  wire logic               rc_busy,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    kind,
    output lslp_pkg::status_t       status,
    output lslp_pkg::addr_t         dest_addr,
    input  wire logic               cfg_we,
    input  wire lslp_pkg::reg_idx_t cfg_index,
    input  wire lslp_pkg::ms_t      cfg_data
);
    import lslp_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RELEASE,
        PH_LEDS_ON,
        PH_LEDS_OFF,
        PH_SETTLE,
        PH_READ,
        PH_HOLD,
        PH_BLINK
    } phase_t;

    lslp_cfg_t cfg;

    lslp_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // input register
    logic       iv_reg, iv_next;
    logic       q_cmd_reg, q_cmd_next;
    addr_t      q_req_reg, q_req_next;
    ms_t        q_now_reg, q_now_next;
    logic       q_rel_reg, q_rel_next;
    logic       q_red_reg, q_red_next;
    logic       q_green_reg, q_green_next;
    logic       q_busy_reg, q_busy_next;

    // probe state
    phase_t     phase_reg, phase_next;
    ms_t        start_time_reg, start_time_next;
    addr_t      saved_addr_reg, saved_addr_next;
    status_t    read_result_reg, read_result_next;
    logic [1:0] last_pair_reg, last_pair_next;
    logic       blink_seen_reg, blink_seen_next;

    // result register
    logic       ov_reg, ov_next;
    logic       o_kind_reg, o_kind_next;
    status_t    o_status_reg, o_status_next;
    addr_t      o_addr_reg, o_addr_next;

    ms_t        elapsed;
    ms_t        limit;
    logic       timed_out;
    logic       both_on;
    logic [1:0] pair;
    logic       emit;
    logic       e_kind;
    status_t    e_status;
    addr_t      e_addr;
    logic       out_free;
    logic       proc_go;

    assign both_on = q_red_reg & q_green_reg;
    assign pair    = {q_red_reg, q_green_reg};
    assign elapsed = q_now_reg - start_time_reg;

    always_comb
    begin
        unique case (phase_reg)
            PH_RELEASE:  limit = cfg.release_to;
            PH_LEDS_ON:  limit = cfg.leds_on_to;
            PH_LEDS_OFF: limit = cfg.leds_off_to;
            PH_SETTLE:   limit = cfg.settle;
            PH_HOLD:     limit = cfg.hold_to;
            PH_BLINK:    limit = cfg.blink_win;
            PH_IDLE,
            PH_READ:     limit = '1;
        endcase
    end

    assign timed_out = elapsed > limit;
    assign out_free  = !ov_reg || out_ready;

    always_comb
    begin
        phase_next       = phase_reg;
        start_time_next  = start_time_reg;
        saved_addr_next  = saved_addr_reg;
        read_result_next = read_result_reg;
        last_pair_next   = last_pair_reg;
        blink_seen_next  = blink_seen_reg;
        emit             = 1'b0;
        e_kind           = KIND_REPLY;
        e_status         = ST_INTERNAL;
        e_addr           = saved_addr_reg;

        if (q_cmd_reg)
        begin
            emit = 1'b1;
            if (phase_reg != PH_IDLE || q_busy_reg)
            begin
                e_status = ST_AGAIN;
                e_addr   = q_req_reg;
            end
            else
            begin
                saved_addr_next = q_req_reg;
                start_time_next = q_now_reg;
                phase_next      = PH_RELEASE;
                e_kind          = KIND_PRESS;
                e_addr          = '0;
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE: ;
                PH_RELEASE:
                begin
                    if (q_rel_reg)
                    begin
                        phase_next      = PH_LEDS_ON;
                        start_time_next = q_now_reg;
                    end
                    else if (timed_out)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        e_status   = ST_INTERNAL;
                    end
                end
                PH_LEDS_ON:
                begin
                    if (both_on)
                    begin
                        phase_next      = PH_LEDS_OFF;
                        start_time_next = q_now_reg;
                    end
                    else if (timed_out)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        e_status   = ST_NOT_ON;
                    end
                end
                PH_LEDS_OFF:
                begin
                    if (!both_on)
                    begin
                        phase_next      = PH_SETTLE;
                        start_time_next = q_now_reg;
                    end
                    else if (timed_out)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        e_status   = ST_NOT_OFF;
                    end
                end
                PH_SETTLE:
                begin
                    if (timed_out)
                    begin
                        phase_next = PH_READ;
                    end
                end
                PH_READ:
                begin
                    start_time_next = q_now_reg;
                    priority if (both_on)
                    begin
                        read_result_next = ST_UNCALIB;
                        phase_next       = PH_HOLD;
                    end
                    else if (q_red_reg)
                    begin
                        read_result_next = ST_UNLOCKED;
                        phase_next       = PH_HOLD;
                    end
                    else if (q_green_reg)
                    begin
                        read_result_next = ST_LOCKED;
                        phase_next       = PH_HOLD;
                    end
                    else
                    begin
                        phase_next = PH_BLINK;
                    end
                end
                PH_HOLD:
                begin
                    if (!both_on || timed_out)
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        e_status   = read_result_reg;
                    end
                end
                PH_BLINK:
                begin
                    last_pair_next = pair;
                    if (timed_out)
                    begin
                        phase_next      = PH_IDLE;
                        emit            = 1'b1;
                        e_status        = (blink_seen_reg || last_pair_reg != pair) ?
                                          ST_NO_CONN : ST_NO_RESP;
                        blink_seen_next = 1'b0;
                        last_pair_next  = '0;
                    end
                    else if (last_pair_reg != pair)
                    begin
                        blink_seen_next = 1'b1;
                    end
                end
            endcase
        end
    end

    assign proc_go  = iv_reg && (!emit || out_free);
    assign in_ready = !iv_reg || proc_go;

    always_comb
    begin
        iv_next      = iv_reg;
        q_cmd_next   = q_cmd_reg;
        q_req_next   = q_req_reg;
        q_now_next   = q_now_reg;
        q_rel_next   = q_rel_reg;
        q_red_next   = q_red_reg;
        q_green_next = q_green_reg;
        q_busy_next  = q_busy_reg;
        if (in_ready)
        begin
            iv_next = in_valid;
            if (in_valid)
            begin
                q_cmd_next   = cmd;
                q_req_next   = requester;
                q_now_next   = now_ms;
                q_rel_next   = btn_released;
                q_red_next   = led_red;
                q_green_next = led_grn;
                q_busy_next  = rc_busy;
            end
        end

        ov_next       = ov_reg && !out_ready;
        o_kind_next   = o_kind_reg;
        o_status_next = o_status_reg;
        o_addr_next   = o_addr_reg;
        if (proc_go && emit)
        begin
            ov_next       = 1'b1;
            o_kind_next   = e_kind;
            o_status_next = e_status;
            o_addr_next   = e_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg          <= 1'b0;
            q_cmd_reg       <= 1'b0;
            q_req_reg       <= '0;
            q_now_reg       <= '0;
            q_rel_reg       <= 1'b0;
            q_red_reg       <= 1'b0;
            q_green_reg     <= 1'b0;
            q_busy_reg      <= 1'b0;
            phase_reg       <= PH_IDLE;
            start_time_reg  <= '0;
            saved_addr_reg  <= '0;
            read_result_reg <= ST_INTERNAL;
            last_pair_reg   <= '0;
            blink_seen_reg  <= 1'b0;
            ov_reg          <= 1'b0;
            o_kind_reg      <= KIND_PRESS;
            o_status_reg    <= ST_INTERNAL;
            o_addr_reg      <= '0;
        end
        else
        begin
            iv_reg      <= iv_next;
            q_cmd_reg   <= q_cmd_next;
            q_req_reg   <= q_req_next;
            q_now_reg   <= q_now_next;
            q_rel_reg   <= q_rel_next;
            q_red_reg   <= q_red_next;
            q_green_reg <= q_green_next;
            q_busy_reg  <= q_busy_next;
            if (proc_go)
            begin
                phase_reg       <= phase_next;
                start_time_reg  <= start_time_next;
                saved_addr_reg  <= saved_addr_next;
                read_result_reg <= read_result_next;
                last_pair_reg   <= last_pair_next;
                blink_seen_reg  <= blink_seen_next;
            end
            ov_reg       <= ov_next;
            o_kind_reg   <= o_kind_next;
            o_status_reg <= o_status_next;
            o_addr_reg   <= o_addr_next;
        end
    end

    assign out_valid = ov_reg;
    assign kind      = o_kind_reg;
    assign status    = o_status_reg;
    assign dest_addr = o_addr_reg;

`ifndef SYNTH
    a_start_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && q_cmd_reg && phase_reg == PH_IDLE && !q_busy_reg)
        |=> (phase_reg == PH_RELEASE))
        else $error("request while idle did not start the probe");

    a_blink_state: assert property (@(posedge clk) disable iff (!rst_n)
        (blink_seen_reg || last_pair_reg != 2'b00) |-> (phase_reg == PH_BLINK))
        else $error("blink tracking left set outside blink watch");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (proc_go && emit) |-> (!ov_reg || out_ready))
        else $error("pending result overwritten");

    a_press_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && o_kind_reg == KIND_PRESS) |-> (o_status_reg == ST_INTERNAL && o_addr_reg == '0))
        else $error("press request carries non-zero fields");
`endif

endmodule

`default_nettype wire
